[hdl/iea_pkg.sv]
package iea_pkg;

	localparam int unsigned IDX_W = 2;

	typedef enum logic [1:0] {
		ALG_RELU   = 2'd0,
		ALG_LINEAR = 2'd1,
		ALG_CLIP   = 2'd2,
		ALG_NONE   = 2'd3
	} alg_t;

	typedef enum logic [1:0] {
		ET_S32 = 2'd0,
		ET_S8  = 2'd1,
		ET_U8  = 2'd2
	} elem_t;

	localparam logic [IDX_W-1:0] REG_ALG   = 2'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA = 2'd1;
	localparam logic [IDX_W-1:0] REG_BETA  = 2'd2;
	localparam logic [IDX_W-1:0] REG_ELEM  = 2'd3;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	localparam logic signed [32:0] S32_LO = 33'sh1_8000_0000;
	localparam logic signed [32:0] S32_HI = 33'sd2147483520;
	localparam logic signed [32:0] S8_LO  = -33'sd128;
	localparam logic signed [32:0] S8_HI  = 33'sd127;
	localparam logic signed [32:0] U8_LO  = 33'sd0;
	localparam logic signed [32:0] U8_HI  = 33'sd255;

	typedef struct packed {
		logic              sign;
		logic              nan;
		logic              inf;
		logic              zero;
		logic signed [9:0] exp;
		logic [23:0]       man;
	} fp_t;

	// Subnormals are taken as zero.
	function automatic fp_t fp_unpack(input logic [31:0] w);
		fp_t f;
		f.sign = w[31];
		f.nan  = (&w[30:23]) && (|w[22:0]);
		f.inf  = (&w[30:23]) && !(|w[22:0]);
		f.zero = (w[30:23] == 8'd0);
		f.exp  = $signed({2'b00, w[30:23]}) - 10'sd127;
		f.man  = f.zero ? 24'd0 : {1'b1, w[22:0]};
		return f;
	endfunction

	function automatic logic [5:0] lzc32(input logic [31:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd32;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 6'(31 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

[hdl/iea_cfg_if.sv]
interface iea_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [iea_pkg::IDX_W-1:0]  index;
	logic [31:0]                wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

[hdl/iea_in_if.sv]
interface iea_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

[hdl/iea_out_if.sv]
interface iea_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

[hdl/int_eltwise_activation.sv]
// Channel   Role    Payload
// cfg       sink    index (register number), wdata
// samples   sink    sample (signed 32-bit element)
// results   source  result (signed 32-bit element)
//
// One item enters per cycle while the results channel is not stalled.
// The pipeline is a chain of stages: widen (2), multiply (2), add (4), convert (3).
// Reset clears the valid bits and the configuration registers to zero.
// A stalled results channel holds the whole pipeline; samples.ready then falls.
// Configuration writes are always taken.
module int_eltwise_activation (
	input  logic      clk,
	input  logic      arst_n,
	iea_cfg_if.sink   cfg,
	iea_in_if.sink    samples,
	iea_out_if.source results
);
	import iea_pkg::*;

	logic [1:0]  alg_q, et_q;
	logic [31:0] alpha_q, beta_q;
	logic        en;

	logic        x_v, p_v, a_v;
	logic [31:0] x_word, prod_word, addend_word, alt_word, sum_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q   <= 2'd0;
			alpha_q <= 32'd0;
			beta_q  <= 32'd0;
			et_q    <= 2'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ALG:   alg_q   <= cfg.wdata[1:0];
				REG_ALPHA: alpha_q <= cfg.wdata;
				REG_BETA:  beta_q  <= cfg.wdata;
				REG_ELEM:  et_q    <= cfg.wdata[1:0];
				default:   ;
			endcase
		end
	end

	assign cfg.ready     = 1'b1;
	assign en            = !results.valid || results.ready;
	assign samples.ready = en;

	iea_int2f u_int2f (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (samples.valid),
		.sample    (samples.sample),
		.elem_type (et_q),
		.out_v     (x_v),
		.x_word    (x_word)
	);

	iea_fmul u_fmul (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_v        (x_v),
		.x_word      (x_word),
		.alpha_word  (alpha_q),
		.beta_word   (beta_q),
		.alg_mode    (alg_q),
		.out_v       (p_v),
		.prod_word   (prod_word),
		.addend_word (addend_word),
		.alt_word    (alt_word)
	);

	iea_fadd u_fadd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (p_v),
		.a_word   (prod_word),
		.b_word   (addend_word),
		.alt_word (alt_word),
		.alg_mode (alg_q),
		.out_v    (a_v),
		.sum_word (sum_word)
	);

	iea_f2i u_f2i (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (a_v),
		.x_word    (sum_word),
		.elem_type (et_q),
		.out_v     (results.valid),
		.result    (results.result)
	);

`ifndef ASSERT_OFF
	a_s8_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && et_q == ET_S8) |->
		(results.result[31:7] == 25'd0 || results.result[31:7] == 25'h1FF_FFFF))
		else $error("s8 result out of range");

	a_u8_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && et_q != ET_S32 && et_q != ET_S8) |->
		(results.result[31:8] == 24'd0))
		else $error("u8 result out of range");

	a_s32_top: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && et_q == ET_S32) |->
		($signed({results.result[31], results.result}) <= S32_HI))
		else $error("s32 result above upper bound");
`endif

endmodule

[hdl/iea_int2f.sv]
module iea_int2f (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic signed [31:0] sample,
	input  logic [1:0]         elem_type,
	output logic               out_v,
	output logic [31:0]        x_word
);
	import iea_pkg::*;

	logic [31:0] ext, mag, norm;
	logic        neg, rnd;
	logic [24:0] r25;
	logic [7:0]  bexp;

	logic        v_s1, neg_s1;
	logic [31:0] mag_s1;
	logic [5:0]  lz_s1;
	logic        v_s2;
	logic [31:0] word_s2;

	always_comb begin
		case (elem_type)
			ET_S32:  ext = sample;
			ET_S8:   ext = {{24{sample[7]}}, sample[7:0]};
			default: ext = {24'd0, sample[7:0]};
		endcase
		neg = ext[31];
		mag = neg ? (~ext + 32'd1) : ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg;
			mag_s1  <= mag;
			lz_s1   <= lzc32(mag);
			word_s2 <= lz_s1[5] ? 32'd0 : {neg_s1, bexp, r25[22:0]};
		end
	end

	always_comb begin
		norm = mag_s1 << lz_s1[4:0];
		rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
		r25  = {1'b0, norm[31:8]} + {24'd0, rnd};
		bexp = (8'd158 - {2'b00, lz_s1}) + {7'd0, r25[24]};
	end

	assign out_v  = v_s2;
	assign x_word = word_s2;

endmodule

[hdl/iea_fmul.sv]
module iea_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [31:0] x_word,
	input  logic [31:0] alpha_word,
	input  logic [31:0] beta_word,
	input  logic [1:0]  alg_mode,
	output logic        out_v,
	output logic [31:0] prod_word,
	output logic [31:0] addend_word,
	output logic [31:0] alt_word
);
	import iea_pkg::*;

	function automatic logic [31:0] fkey(input logic [31:0] w);
		return w[31] ? ~w : {1'b1, w[30:0]};
	endfunction

	function automatic logic is_nan(input logic [31:0] w);
		return (&w[30:23]) && (|w[22:0]);
	endfunction

	function automatic logic [31:0] fmin(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (is_nan(a) && is_nan(b)) r = QNAN;
		else if (is_nan(a))         r = b;
		else if (is_nan(b))         r = a;
		else                        r = (fkey(a) <= fkey(b)) ? a : b;
		return r;
	endfunction

	function automatic logic [31:0] fmax(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (is_nan(a) && is_nan(b)) r = QNAN;
		else if (is_nan(a))         r = b;
		else if (is_nan(b))         r = a;
		else                        r = (fkey(a) >= fkey(b)) ? a : b;
		return r;
	endfunction

	fp_t         ua, ub;
	logic [31:0] opb, addend, alt;

	logic               v_s1, sign_s1, nan_s1, inf_s1, zero_s1;
	logic [47:0]        prod_s1;
	logic signed [9:0]  exp_s1;
	logic [31:0]        addend_s1, alt_s1;

	logic               v_s2;
	logic [31:0]        prod_s2, addend_s2, alt_s2;

	logic [23:0]        m;
	logic               g, st, rnd;
	logic [24:0]        r25;
	logic signed [9:0]  e, be;
	logic [31:0]        pw;

	always_comb begin
		opb    = (alg_mode == ALG_RELU && !x_word[31]) ? 32'd0 : x_word;
		addend = (alg_mode == ALG_LINEAR) ? beta_word : (x_word[31] ? 32'd0 : x_word);
		alt    = (alg_mode == ALG_CLIP) ? fmax(alpha_word, fmin(beta_word, x_word)) : x_word;
		ua     = fp_unpack(alpha_word);
		ub     = fp_unpack(opb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= ua.man * ub.man;
			exp_s1    <= ua.exp + ub.exp;
			sign_s1   <= ua.sign ^ ub.sign;
			nan_s1    <= ua.nan | (ua.inf & ub.zero);
			inf_s1    <= ua.inf & !ub.zero;
			zero_s1   <= ua.zero | ub.zero;
			addend_s1 <= addend;
			alt_s1    <= alt;
			prod_s2   <= pw;
			addend_s2 <= addend_s1;
			alt_s2    <= alt_s1;
		end
	end

	always_comb begin
		if (prod_s1[47]) begin
			m  = prod_s1[47:24];
			g  = prod_s1[23];
			st = |prod_s1[22:0];
			e  = exp_s1 + 10'sd1;
		end else begin
			m  = prod_s1[46:23];
			g  = prod_s1[22];
			st = |prod_s1[21:0];
			e  = exp_s1;
		end
		rnd = g & (st | m[0]);
		r25 = {1'b0, m} + {24'd0, rnd};
		be  = e + 10'sd127 + $signed({9'd0, r25[24]});
		if (nan_s1)              pw = QNAN;
		else if (inf_s1)         pw = {sign_s1, 8'hFF, 23'd0};
		else if (zero_s1)        pw = {sign_s1, 31'd0};
		else if (be >= 10'sd255) pw = {sign_s1, 8'hFF, 23'd0};
		else if (be <= 10'sd0)   pw = {sign_s1, 31'd0};
		else                     pw = {sign_s1, be[7:0], r25[22:0]};
	end

	assign out_v       = v_s2;
	assign prod_word   = prod_s2;
	assign addend_word = addend_s2;
	assign alt_word    = alt_s2;

endmodule

[hdl/iea_fadd.sv]
module iea_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [31:0] a_word,
	input  logic [31:0] b_word,
	input  logic [31:0] alt_word,
	input  logic [1:0]  alg_mode,
	output logic        out_v,
	output logic [31:0] sum_word
);
	import iea_pkg::*;

	fp_t         ua, ub, ubig, usml;
	logic [30:0] ma, mb;
	logic        a_big;

	logic        v_s1, sign_s1, sub_s1, nan_s1, inf_s1, isign_s1;
	logic [7:0]  exp_s1, d_s1;
	logic [23:0] mb_s1, ms_s1;
	logic [31:0] alt_s1;

	logic        v_s2, sign_s2, nan_s2, inf_s2, isign_s2;
	logic [7:0]  exp_s2;
	logic [27:0] sum_s2;
	logic [31:0] alt_s2;

	logic              v_s3, sign_s3, nan_s3, inf_s3, isign_s3, zero_s3;
	logic [26:0]       n_s3;
	logic signed [9:0] e_s3;
	logic [31:0]       alt_s3;

	logic        v_s4;
	logic [31:0] word_s4;

	logic [26:0]       se, shd, al;
	logic [27:0]       sum;
	logic [26:0]       n;
	logic signed [9:0] e;
	logic [5:0]        lz;
	logic [23:0]       m;
	logic              rnd;
	logic [24:0]       r25;
	logic signed [9:0] be;
	logic [31:0]       sw;

	always_comb begin
		ua    = fp_unpack(a_word);
		ub    = fp_unpack(b_word);
		ma    = ua.zero ? 31'd0 : a_word[30:0];
		mb    = ub.zero ? 31'd0 : b_word[30:0];
		a_big = (ma >= mb);
		ubig  = a_big ? ua : ub;
		usml  = a_big ? ub : ua;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1  <= ubig.sign;
			sub_s1   <= ua.sign ^ ub.sign;
			exp_s1   <= ubig.zero ? 8'd0 : 8'(ubig.exp + 10'sd127);
			d_s1     <= (ubig.zero ? 8'd0 : 8'(ubig.exp + 10'sd127))
				- (usml.zero ? 8'd0 : 8'(usml.exp + 10'sd127));
			mb_s1    <= ubig.man;
			ms_s1    <= usml.man;
			nan_s1   <= ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign ^ ub.sign));
			inf_s1   <= ua.inf | ub.inf;
			isign_s1 <= ua.inf ? ua.sign : ub.sign;
			alt_s1   <= alt_word;

			sum_s2   <= sum;
			exp_s2   <= exp_s1;
			sign_s2  <= sign_s1;
			nan_s2   <= nan_s1;
			inf_s2   <= inf_s1;
			isign_s2 <= isign_s1;
			alt_s2   <= alt_s1;

			n_s3     <= n;
			e_s3     <= e;
			zero_s3  <= (sum_s2 == 28'd0);
			sign_s3  <= sign_s2;
			nan_s3   <= nan_s2;
			inf_s3   <= inf_s2;
			isign_s3 <= isign_s2;
			alt_s3   <= alt_s2;

			word_s4  <= (alg_mode == ALG_RELU || alg_mode == ALG_LINEAR) ? sw : alt_s3;
		end
	end

	always_comb begin
		se = {ms_s1, 3'b000};
		if (d_s1 >= 8'd27) begin
			shd = 27'd0;
			al  = {26'd0, |ms_s1};
		end else begin
			shd = se >> d_s1[4:0];
			al  = shd | {26'd0, ((shd << d_s1[4:0]) != se)};
		end
		sum = sub_s1 ? ({1'b0, mb_s1, 3'b000} - {1'b0, al})
			: ({1'b0, mb_s1, 3'b000} + {1'b0, al});
	end

	always_comb begin
		lz = lzc32({sum_s2[26:0], 5'd0});
		if (sum_s2[27]) begin
			n = {sum_s2[27:2], |sum_s2[1:0]};
			e = $signed({2'b00, exp_s2}) + 10'sd1;
		end else begin
			n = sum_s2[26:0] << lz[4:0];
			e = $signed({2'b00, exp_s2}) - $signed({4'd0, lz});
		end
	end

	always_comb begin
		m   = n_s3[26:3];
		rnd = n_s3[2] & ((|n_s3[1:0]) | m[0]);
		r25 = {1'b0, m} + {24'd0, rnd};
		be  = e_s3 + $signed({9'd0, r25[24]});
		if (nan_s3)              sw = QNAN;
		else if (inf_s3)         sw = {isign_s3, 8'hFF, 23'd0};
		else if (zero_s3)        sw = 32'd0;
		else if (be >= 10'sd255) sw = {sign_s3, 8'hFF, 23'd0};
		else if (be <= 10'sd0)   sw = {sign_s3, 31'd0};
		else                     sw = {sign_s3, be[7:0], r25[22:0]};
	end

	assign out_v    = v_s4;
	assign sum_word = word_s4;

endmodule

[hdl/iea_f2i.sv]
module iea_f2i (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [31:0]        x_word,
	input  logic [1:0]         elem_type,
	output logic               out_v,
	output logic signed [31:0] result
);
	import iea_pkg::*;

	fp_t               u;
	logic              fin, tiny;
	logic [5:0]        sh;
	logic [56:0]       fx;

	logic              v_s1, g_s1, st_s1, sign_s1, lo_s1, hi_s1;
	logic [31:0]       int_s1;
	logic              v_s2, lo_s2, hi_s2;
	logic signed [32:0] val_s2;
	logic              v_s3;
	logic signed [31:0] res_s3;

	logic [31:0]        mag;
	logic signed [32:0] lo, hi, r;

	always_comb begin
		u    = fp_unpack(x_word);
		fin  = !u.nan && !u.inf && !u.zero;
		tiny = u.zero || (u.exp < -10'sd1);
		sh   = 6'(u.exp + 10'sd2);
		fx   = (fin && !tiny && u.exp < 10'sd31) ? ({33'd0, u.man} << sh) : 57'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			int_s1  <= fx[56:25];
			g_s1    <= fx[24];
			st_s1   <= |fx[23:0];
			sign_s1 <= u.sign;
			lo_s1   <= u.nan || (u.inf && u.sign) || (fin && u.exp >= 10'sd31 && u.sign);
			hi_s1   <= (u.inf && !u.sign) || (fin && u.exp >= 10'sd31 && !u.sign);
			val_s2  <= sign_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			res_s3  <= r[31:0];
		end
	end

	assign mag = int_s1 + {31'd0, g_s1 & (st_s1 | int_s1[0])};

	always_comb begin
		case (elem_type)
			ET_S32: begin
				lo = S32_LO;
				hi = S32_HI;
			end
			ET_S8: begin
				lo = S8_LO;
				hi = S8_HI;
			end
			default: begin
				lo = U8_LO;
				hi = U8_HI;
			end
		endcase
		if (lo_s2)             r = lo;
		else if (hi_s2)        r = hi;
		else if (val_s2 < lo)  r = lo;
		else if (val_s2 > hi)  r = hi;
		else                   r = val_s2;
	end

	assign out_v  = v_s3;
	assign result = res_s3;

endmodule

[tb/iea_checker.sv]
`timescale 1ns / 100ps

module iea_checker (
	input  logic      clk,
	input  logic      arst_n,
	iea_cfg_if        cfg,
	iea_in_if         smp,
	iea_out_if        res,
	output int        errors,
	output int        pending
);
	import iea_pkg::*;

	logic [1:0]  mode_q;
	logic [31:0] alpha_q;
	logic [31:0] beta_q;
	logic [1:0]  etype_q;

	logic [31:0] expected_q[$];

	function automatic real f32_to_real(input logic [31:0] w);
		logic [7:0]  e;
		logic [23:0] f;
		int          ex;
		e = w[30:23];
		f = {1'b0, w[22:0]};
		if (e == 8'hFF) begin
			if (f != 0)
				return $bitstoreal(64'h7FF8_0000_0000_0000);
			return $bitstoreal({w[31], 11'h7FF, 52'd0});
		end
		if (e == 8'd0) begin
			if (f == 0)
				return $bitstoreal({w[31], 63'd0});
			ex = -126;
			while (!f[23]) begin
				f = f << 1;
				ex--;
			end
			return $bitstoreal({w[31], 11'(ex + 1023), f[22:0], 29'd0});
		end
		return $bitstoreal({w[31], 11'(int'(e) - 127 + 1023), w[22:0], 29'd0});
	endfunction

	function automatic logic [31:0] round_to_f32(input real r);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic        s;
		int          ee;
		int          sh;
		d = $realtobits(r);
		s = d[63];
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'd0};
		if (d[62:52] == 11'd0)
			return {s, 31'd0};
		ee = int'(d[62:52]) - 1023;
		if (ee > 127)
			return {s, 8'hFF, 23'd0};
		m = {11'd0, 1'b1, d[51:0]};
		sh = (ee >= -126) ? 29 : 29 + (-126 - ee);
		if (sh > 60)
			return {s, 31'd0};
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		if (ee >= -126) begin
			if (q == (64'd1 << 24)) begin
				q = q >> 1;
				ee++;
			end
			if (ee > 127)
				return {s, 8'hFF, 23'd0};
			return {s, 8'(ee + 127), q[22:0]};
		end
		return {s, q[30:0]};
	endfunction

	function automatic logic is_nan(input logic [31:0] w);
		return (&w[30:23]) && (|w[22:0]);
	endfunction

	function automatic logic [31:0] fmax(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) && is_nan(b))
			return QNAN;
		if (is_nan(a))
			return b;
		if (is_nan(b))
			return a;
		if (f32_to_real(a) == f32_to_real(b))
			return a[31] ? b : a;
		return (f32_to_real(a) > f32_to_real(b)) ? a : b;
	endfunction

	function automatic logic [31:0] fmin(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) && is_nan(b))
			return QNAN;
		if (is_nan(a))
			return b;
		if (is_nan(b))
			return a;
		if (f32_to_real(a) == f32_to_real(b))
			return a[31] ? a : b;
		return (f32_to_real(a) < f32_to_real(b)) ? a : b;
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		return round_to_f32(f32_to_real(a) * f32_to_real(b));
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		return round_to_f32(f32_to_real(a) + f32_to_real(b));
	endfunction

	function automatic logic [31:0] widen(input logic signed [31:0] v);
		return round_to_f32($itor(v));
	endfunction

	function automatic logic [31:0] f32_to_int(input logic [31:0] w);
		logic [7:0]  e;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int          sh;
		e = w[30:23];
		if (e == 8'd0)
			return 32'd0;
		m = {40'd0, 1'b1, w[22:0]};
		if (e >= 8'd150) begin
			sh = int'(e) - 150;
			if (sh > 8)
				sh = 8;
			q = m << sh;
		end else begin
			sh = 150 - int'(e);
			if (sh > 24)
				return 32'd0;
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			q = m >> sh;
			if (rem > half || (rem == half && q[0]))
				q++;
		end
		return w[31] ? (32'd0 - q[31:0]) : q[31:0];
	endfunction

	function automatic logic [31:0] activate(input logic [31:0] raw);
		logic [31:0] x;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] r;
		case (etype_q)
			ET_S32: begin
				x = widen(raw);
				lo = widen(32'h8000_0000);
				hi = widen(32'sd2147483520);
			end
			ET_S8: begin
				x = widen({{24{raw[7]}}, raw[7:0]});
				lo = widen(-32'sd128);
				hi = widen(32'sd127);
			end
			default: begin
				x = widen({24'd0, raw[7:0]});
				lo = widen(32'sd0);
				hi = widen(32'sd255);
			end
		endcase
		case (alg_t'(mode_q))
			ALG_RELU:   x = fadd(fmax(x, 32'd0), fmul(alpha_q, fmin(x, 32'd0)));
			ALG_LINEAR: x = fadd(fmul(alpha_q, x), beta_q);
			ALG_CLIP:   x = fmax(fmin(x, beta_q), alpha_q);
			default: ;
		endcase
		x = fmin(fmax(x, lo), hi);
		r = f32_to_int(x);
		if (etype_q == ET_S8)
			r = {{24{r[7]}}, r[7:0]};
		else if (etype_q != ET_S32)
			r = {24'd0, r[7:0]};
		return r;
	endfunction

	task automatic report(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = 2'd0;
			alpha_q = 32'd0;
			beta_q = 32'd0;
			etype_q = 2'd0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ALG:   mode_q = cfg.wdata[1:0];
				REG_ALPHA: alpha_q = cfg.wdata;
				REG_BETA:  beta_q = cfg.wdata;
				REG_ELEM:  etype_q = cfg.wdata[1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (smp.valid && smp.ready)
				expected_q.push_back(activate(smp.sample));
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("result %h with no item outstanding", res.result));
				end else begin
					want = expected_q.pop_front();
					if (res.result !== want)
						report($sformatf("result %h, expected %h", res.result, want));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import iea_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	iea_cfg_if cfg ();
	iea_in_if  smp ();
	iea_out_if res ();

	int_eltwise_activation i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (smp),
		.results (res)
	);

	iea_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.smp     (smp),
		.res     (res),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_float();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom;
		if (r == 1) begin
			case ($urandom_range(0, 7))
				0: return 32'h7F80_0000;
				1: return 32'hFF80_0000;
				2: return 32'h7FC0_0000;
				3: return 32'hFFA0_0001;
				4: return 32'h0000_0000;
				5: return 32'h8000_0000;
				6: return 32'h0000_0001;
				default: return 32'h7F7F_FFFF;
			endcase
		end
		return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
	endfunction

	function automatic logic [31:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom;
		if (r < 8)
			return 32'($urandom_range(0, 600)) - 32'd300;
		if (r == 8)
			return 32'h7FFF_FF00 + 32'($urandom_range(0, 255));
		return 32'h8000_0000 + 32'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic setup(input logic [1:0] alg, input logic [31:0] alpha,
			input logic [31:0] beta, input logic [1:0] et);
		drain();
		write_reg(REG_ALG, {30'd0, alg});
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		write_reg(REG_ELEM, {30'd0, et});
	endtask

	task automatic send(input logic [31:0] v);
		int g;
		smp.valid  <= 1'b1;
		smp.sample <= v;
		do @(posedge clk); while (!smp.ready);
		g = pick_gap();
		if (g > 0) begin
			smp.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic finish_burst();
		smp.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int g;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				res.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = '0;
		cfg.wdata  = '0;
		smp.valid  = 1'b0;
		smp.sample = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		setup(ALG_RELU, 32'h3F00_0000, 32'h0000_0000, ET_S32);
		send(32'd0);
		send(32'd1);
		send(32'hFFFF_FFFF);
		send(32'h7FFF_FFFF);
		send(32'h8000_0000);
		send(32'h7FFF_FFC0);
		send(32'h7FFF_FF40);
		send(32'h0100_0001);
		send(-32'sd3);
		finish_burst();

		setup(ALG_LINEAR, 32'h3FC0_0000, 32'hC020_0000, ET_S8);
		send(32'h0000_007F);
		send(32'h0000_0080);
		send(32'hFFFF_FF01);
		send(32'h1234_5600);
		finish_burst();

		setup(ALG_CLIP, 32'hC120_0000, 32'h42C8_0000, ET_U8);
		send(32'h0000_0000);
		send(32'hFFFF_FFFF);
		send(32'h0000_0032);
		send(32'h0000_00C8);
		finish_burst();

		setup(ALG_LINEAR, 32'h7FC0_0000, 32'h3F80_0000, ET_S32);
		send(32'd5);
		finish_burst();

		setup(ALG_NONE, 32'h3F80_0000, 32'h3F80_0000, 2'd3);
		send(32'hABCD_01FF);
		finish_burst();

		setup(ALG_LINEAR, 32'h7F80_0000, 32'h0000_0000, ET_S32);
		send(32'd0);
		send(32'd7);
		send(-32'sd7);
		finish_burst();

		for (int p = 0; p < 30; p++) begin
			setup(2'($urandom_range(0, 3)), pick_float(), pick_float(),
				2'($urandom_range(0, 3)));
			for (int i = 0; i < 50; i++)
				send(pick_sample());
			finish_burst();
		end

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
